FILE: rtl/r2k_pkg.sv
// Package: constants, rule table and helper functions for the romaji to kana converter.
package r2k_pkg;

    localparam int RULE_COUNT_DEF  = 150;
    localparam int MAX_PENDING_DEF = 4;
    localparam int ROM_SIZE        = 150;
    localparam int RESULT_LIMIT    = 5;

    localparam logic [15:0] KANA_SMALL_TSU = 16'h3063;
    localparam logic [15:0] KANA_N         = 16'h3093;
    localparam logic [15:0] KATA_LIMIT     = 16'h30A0;
    localparam logic [15:0] KATA_OFFSET    = 16'h0060;

    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_Z = 8'h7A;

    // Work item from the front end to the back end
    typedef struct packed {
        logic       flush;
        logic [7:0] ch;
    } t_cmd;

    // One rule: text bytes (byte 0 first, zero padded), length, two kana
    typedef struct packed {
        logic [31:0] text;
        logic [2:0]  len;
        logic [15:0] k0;
        logic [15:0] k1;
    } t_rule;

    function automatic t_rule mk(input string s, input logic [15:0] a, input logic [15:0] b);
        t_rule r;
        r.text = '0;
        r.len  = 3'(s.len());
        for (int i = 0; i < 4; i++) begin
            if (i < s.len()) r.text[i*8 +: 8] = s[i];
        end
        r.k0 = a;
        r.k1 = b;
        return r;
    endfunction

    function automatic t_rule rule_at(input logic [7:0] idx);
        t_rule r;
        r = mk("", 16'h0, 16'h0);
        unique case (idx)
            8'd0: r = mk("a",16'h3042,0);     8'd1: r = mk("i",16'h3044,0);
            8'd2: r = mk("u",16'h3046,0);     8'd3: r = mk("e",16'h3048,0);
            8'd4: r = mk("o",16'h304A,0);     8'd5: r = mk("ka",16'h304B,0);
            8'd6: r = mk("ki",16'h304D,0);    8'd7: r = mk("ku",16'h304F,0);
            8'd8: r = mk("ke",16'h3051,0);    8'd9: r = mk("ko",16'h3053,0);
            8'd10: r = mk("kya",16'h304D,16'h3083); 8'd11: r = mk("kyu",16'h304D,16'h3085);
            8'd12: r = mk("kyo",16'h304D,16'h3087); 8'd13: r = mk("sa",16'h3055,0);
            8'd14: r = mk("shi",16'h3057,0);  8'd15: r = mk("si",16'h3057,0);
            8'd16: r = mk("su",16'h3059,0);   8'd17: r = mk("se",16'h305B,0);
            8'd18: r = mk("so",16'h305D,0);   8'd19: r = mk("sha",16'h3057,16'h3083);
            8'd20: r = mk("sya",16'h3057,16'h3083); 8'd21: r = mk("shu",16'h3057,16'h3085);
            8'd22: r = mk("syu",16'h3057,16'h3085); 8'd23: r = mk("sho",16'h3057,16'h3087);
            8'd24: r = mk("syo",16'h3057,16'h3087); 8'd25: r = mk("she",16'h3057,16'h3047);
            8'd26: r = mk("ta",16'h305F,0);   8'd27: r = mk("chi",16'h3061,0);
            8'd28: r = mk("ti",16'h3061,0);   8'd29: r = mk("tsu",16'h3064,0);
            8'd30: r = mk("tu",16'h3064,0);   8'd31: r = mk("te",16'h3066,0);
            8'd32: r = mk("to",16'h3068,0);   8'd33: r = mk("cha",16'h3061,16'h3083);
            8'd34: r = mk("tya",16'h3061,16'h3083); 8'd35: r = mk("chu",16'h3061,16'h3085);
            8'd36: r = mk("tyu",16'h3061,16'h3085); 8'd37: r = mk("cho",16'h3061,16'h3087);
            8'd38: r = mk("tyo",16'h3061,16'h3087); 8'd39: r = mk("che",16'h3061,16'h3047);
            8'd40: r = mk("tsa",16'h3064,16'h3041); 8'd41: r = mk("tsi",16'h3064,16'h3043);
            8'd42: r = mk("tse",16'h3064,16'h3047); 8'd43: r = mk("tso",16'h3064,16'h3049);
            8'd44: r = mk("na",16'h306A,0);   8'd45: r = mk("ni",16'h306B,0);
            8'd46: r = mk("nu",16'h306C,0);   8'd47: r = mk("ne",16'h306D,0);
            8'd48: r = mk("no",16'h306E,0);   8'd49: r = mk("nya",16'h306B,16'h3083);
            8'd50: r = mk("nyu",16'h306B,16'h3085); 8'd51: r = mk("nyo",16'h306B,16'h3087);
            8'd52: r = mk("nn",16'h3093,0);   8'd53: r = mk("n'",16'h3093,0);
            8'd54: r = mk("ha",16'h306F,0);   8'd55: r = mk("hi",16'h3072,0);
            8'd56: r = mk("fu",16'h3075,0);   8'd57: r = mk("hu",16'h3075,0);
            8'd58: r = mk("he",16'h3078,0);   8'd59: r = mk("ho",16'h307B,0);
            8'd60: r = mk("hya",16'h3072,16'h3083); 8'd61: r = mk("hyu",16'h3072,16'h3085);
            8'd62: r = mk("hyo",16'h3072,16'h3087); 8'd63: r = mk("fa",16'h3075,16'h3041);
            8'd64: r = mk("fi",16'h3075,16'h3043);  8'd65: r = mk("fe",16'h3075,16'h3047);
            8'd66: r = mk("fo",16'h3075,16'h3049);  8'd67: r = mk("fyu",16'h3075,16'h3085);
            8'd68: r = mk("ma",16'h307E,0);   8'd69: r = mk("mi",16'h307F,0);
            8'd70: r = mk("mu",16'h3080,0);   8'd71: r = mk("me",16'h3081,0);
            8'd72: r = mk("mo",16'h3082,0);   8'd73: r = mk("mya",16'h307F,16'h3083);
            8'd74: r = mk("myu",16'h307F,16'h3085); 8'd75: r = mk("myo",16'h307F,16'h3087);
            8'd76: r = mk("ya",16'h3084,0);   8'd77: r = mk("yu",16'h3086,0);
            8'd78: r = mk("yo",16'h3088,0);   8'd79: r = mk("ra",16'h3089,0);
            8'd80: r = mk("ri",16'h308A,0);   8'd81: r = mk("ru",16'h308B,0);
            8'd82: r = mk("re",16'h308C,0);   8'd83: r = mk("ro",16'h308D,0);
            8'd84: r = mk("rya",16'h308A,16'h3083); 8'd85: r = mk("ryu",16'h308A,16'h3085);
            8'd86: r = mk("ryo",16'h308A,16'h3087); 8'd87: r = mk("wa",16'h308F,0);
            8'd88: r = mk("wi",16'h3046,16'h3043);  8'd89: r = mk("we",16'h3046,16'h3047);
            8'd90: r = mk("wo",16'h3092,0);   8'd91: r = mk("ga",16'h304C,0);
            8'd92: r = mk("gi",16'h304E,0);   8'd93: r = mk("gu",16'h3050,0);
            8'd94: r = mk("ge",16'h3052,0);   8'd95: r = mk("go",16'h3054,0);
            8'd96: r = mk("gya",16'h304E,16'h3083); 8'd97: r = mk("gyu",16'h304E,16'h3085);
            8'd98: r = mk("gyo",16'h304E,16'h3087); 8'd99: r = mk("za",16'h3056,0);
            8'd100: r = mk("ji",16'h3058,0);  8'd101: r = mk("zi",16'h3058,0);
            8'd102: r = mk("zu",16'h305A,0);  8'd103: r = mk("ze",16'h305C,0);
            8'd104: r = mk("zo",16'h305E,0);  8'd105: r = mk("ja",16'h3058,16'h3083);
            8'd106: r = mk("zya",16'h3058,16'h3083); 8'd107: r = mk("ju",16'h3058,16'h3085);
            8'd108: r = mk("zyu",16'h3058,16'h3085); 8'd109: r = mk("jo",16'h3058,16'h3087);
            8'd110: r = mk("zyo",16'h3058,16'h3087); 8'd111: r = mk("je",16'h3058,16'h3047);
            8'd112: r = mk("da",16'h3060,0);  8'd113: r = mk("di",16'h3062,0);
            8'd114: r = mk("du",16'h3065,0);  8'd115: r = mk("de",16'h3067,0);
            8'd116: r = mk("do",16'h3069,0);  8'd117: r = mk("ba",16'h3070,0);
            8'd118: r = mk("bi",16'h3073,0);  8'd119: r = mk("bu",16'h3076,0);
            8'd120: r = mk("be",16'h3079,0);  8'd121: r = mk("bo",16'h307C,0);
            8'd122: r = mk("bya",16'h3073,16'h3083); 8'd123: r = mk("byu",16'h3073,16'h3085);
            8'd124: r = mk("byo",16'h3073,16'h3087); 8'd125: r = mk("pa",16'h3071,0);
            8'd126: r = mk("pi",16'h3074,0);  8'd127: r = mk("pu",16'h3077,0);
            8'd128: r = mk("pe",16'h307A,0);  8'd129: r = mk("po",16'h307D,0);
            8'd130: r = mk("pya",16'h3074,16'h3083); 8'd131: r = mk("pyu",16'h3074,16'h3085);
            8'd132: r = mk("pyo",16'h3074,16'h3087); 8'd133: r = mk("va",16'h3094,16'h3041);
            8'd134: r = mk("vi",16'h3094,16'h3043);  8'd135: r = mk("vu",16'h3094,0);
            8'd136: r = mk("ve",16'h3094,16'h3047);  8'd137: r = mk("vo",16'h3094,16'h3049);
            8'd138: r = mk("xa",16'h3041,0);  8'd139: r = mk("xi",16'h3043,0);
            8'd140: r = mk("xu",16'h3045,0);  8'd141: r = mk("xe",16'h3047,0);
            8'd142: r = mk("xo",16'h3049,0);  8'd143: r = mk("xya",16'h3083,0);
            8'd144: r = mk("xyu",16'h3085,0); 8'd145: r = mk("xyo",16'h3087,0);
            8'd146: r = mk("xtsu",16'h3063,0); 8'd147: r = mk("xtu",16'h3063,0);
            8'd148: r = mk("xwa",16'h308E,0); 8'd149: r = mk("-",16'h30FC,0);
            default: r = mk("", 16'h0, 16'h0);
        endcase
        return r;
    endfunction

    // Hiragana to the selected script; the long vowel mark is shared
    function automatic logic [15:0] to_script(input logic [15:0] h, input logic kata);
        return (kata && h < KATA_LIMIT) ? h + KATA_OFFSET : h;
    endfunction

    function automatic logic is_cons(input logic [7:0] c);
        return c >= CH_A && c <= CH_Z && c != 8'h61 && c != 8'h69 && c != 8'h75 &&
               c != 8'h65 && c != 8'h6F && c != CH_N;
    endfunction

endpackage

FILE: rtl/romaji_to_kana_converter.sv
// Top level of the romaji to kana converter.
// Usage:
//  Input channel (s_axis): tdata[7:0] = char_in, tuser = action (0 feed, 1 flush).
//  Output channel (m_axis): tdata[15:0] = symbol, tuser = is_raw_byte,
//  tlast marks the final result caused by one input item.
//  A feed that only extends a valid prefix, or a flush of an empty buffer,
//  gives no result.
//  i_kana_mode_we writes the script bit (0 hiragana, 1 katakana) at once.
//  An item sits in a two-entry queue; the back end takes it when it is idle
//  and the result register is free, and scans the rule table one rule per
//  cycle. A typed byte holds the back end through take, scan and decide.
//  Each byte resolved without a match adds a rescan of the table, a second
//  kana one more decide step. A flush emits pending bytes one at a time,
//  and one item is handled at a time.
//  Reset (synchronous, active low) empties queue and pending buffer and
//  selects hiragana. When the receiver stalls, the result register holds
//  and the back end waits; the queue keeps taking items until full.
module romaji_to_kana_converter #(
    parameter int RULE_COUNT  = r2k_pkg::RULE_COUNT_DEF,
    parameter int MAX_PENDING = r2k_pkg::MAX_PENDING_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_kana_mode_we,
    input  logic        i_kana_mode,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] symbol
    output logic        m_axis_tuser,   // [0] is_raw_byte
    output logic        m_axis_tlast
);
    logic          r_kata;
    r2k_pkg::t_cmd w_in;
    r2k_pkg::t_cmd w_q;
    logic          w_qv;
    logic          w_take;

    // script register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_kata <= 1'b0;
        else if (i_kana_mode_we) r_kata <= i_kana_mode;
    end

    assign w_in.flush = s_axis_tuser;
    assign w_in.ch    = s_axis_tdata;

    r2k_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(w_in),
        .o_valid(w_qv), .i_take(w_take), .o_cmd(w_q)
    );

    r2k_back #(.RULE_COUNT(RULE_COUNT), .MAX_PENDING(MAX_PENDING)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_kata(r_kata),
        .i_valid(w_qv), .o_take(w_take), .i_cmd(w_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_symbol(m_axis_tdata), .o_raw(m_axis_tuser), .o_last(m_axis_tlast)
    );
endmodule

FILE: rtl/r2k_front.sv
// Front end: input handshake and a two-entry command queue.
module r2k_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  r2k_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_take,
    output r2k_pkg::t_cmd o_cmd
);
    r2k_pkg::t_cmd r_q [2];
    logic          r_rd;
    logic          r_wr;
    logic [1:0]    r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rd];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) r_q[r_wr] <= i_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) r_wr <= ~r_wr;
            if (o_valid && i_take) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_valid && i_take);
        end
    end
endmodule

FILE: rtl/r2k_back.sv
// Back end: pending buffer, rule scan over the table and result emission.
module r2k_back #(
    parameter int RULE_COUNT  = r2k_pkg::RULE_COUNT_DEF,
    parameter int MAX_PENDING = r2k_pkg::MAX_PENDING_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_kata,
    input  logic          i_valid,
    output logic          o_take,
    input  r2k_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [15:0]   o_symbol,
    output logic          o_raw,
    output logic          o_last
);
    localparam int NRULE = (RULE_COUNT < r2k_pkg::ROM_SIZE) ? RULE_COUNT : r2k_pkg::ROM_SIZE;
    localparam int CW    = $clog2(MAX_PENDING + 1);
    localparam int PW    = $clog2(MAX_PENDING);

    typedef enum logic [2:0] {S_IDLE, S_FLUSH, S_SCAN, S_DECIDE, S_EMIT} t_state;

    t_state           r_state;
    logic [7:0]       r_buf [MAX_PENDING];
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_fidx;
    logic [7:0]       r_ridx;
    logic             r_exact;
    logic             r_pref;
    r2k_pkg::t_rule   r_hit;
    logic [2:0]       r_emitted;
    // one pending result, emitted through the output register
    logic [15:0]      r_sym;
    logic             r_raw;
    logic             r_last;
    logic             r_ovalid;
    // second kana of a rule still to go
    logic             r_k1pend;
    // resolved byte held in r_sym until the rescan tells whether it is last
    logic             r_fin;

    r2k_pkg::t_rule   w_rule;
    logic             w_head;
    logic             w_cap;

    assign w_rule = r2k_pkg::rule_at(r_ridx);
    assign w_cap  = (r_emitted < 3'(r2k_pkg::RESULT_LIMIT));

    // head compare of current rule against the buffer
    always_comb begin
        w_head = 1'b1;
        for (int i = 0; i < MAX_PENDING; i++) begin
            if (i < 4 && CW'(i) < r_cnt && w_rule.text[(i%4)*8 +: 8] != r_buf[i]) w_head = 1'b0;
            if (i >= 4 && CW'(i) < r_cnt) w_head = 1'b0;
        end
    end

    assign o_take   = (r_state == S_IDLE) && i_valid && (!r_ovalid || i_ready);
    assign o_valid  = r_ovalid;
    assign o_symbol = r_sym;
    assign o_raw    = r_raw;
    assign o_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_ovalid  <= 1'b0;
            r_k1pend  <= 1'b0;
            r_fin     <= 1'b0;
            r_emitted <= '0;
            r_fidx    <= '0;
            r_ridx    <= '0;
            r_exact   <= 1'b0;
            r_pref    <= 1'b0;
            for (int i = 0; i < MAX_PENDING; i++) r_buf[i] <= '0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_emitted <= '0;
                    if (o_take) begin
                        if (i_cmd.flush) begin
                            r_fidx  <= '0;
                            r_state <= S_FLUSH;
                        end else if (r_cnt >= CW'(MAX_PENDING)) begin
                            // full buffer: oldest goes out raw first
                            r_sym     <= 16'(r_buf[0]);
                            r_raw     <= 1'b1;
                            for (int i = 0; i < MAX_PENDING - 1; i++) r_buf[i] <= r_buf[i+1];
                            r_buf[PW'(MAX_PENDING-1)] <= i_cmd.ch;
                            r_fin   <= 1'b1;
                            r_ridx  <= '0;
                            r_exact <= 1'b0;
                            r_pref  <= 1'b0;
                            r_state <= S_EMIT;
                        end else begin
                            r_buf[r_cnt[PW-1:0]] <= i_cmd.ch;
                            r_cnt   <= r_cnt + 1'b1;
                            r_ridx  <= '0;
                            r_exact <= 1'b0;
                            r_pref  <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_ovalid || i_ready) begin
                        if (r_cnt == CW'(1) && r_buf[0] == r2k_pkg::CH_N) begin
                            r_sym    <= r2k_pkg::to_script(r2k_pkg::KANA_N, i_kata);
                            r_raw    <= 1'b0;
                            r_last   <= 1'b1;
                            r_ovalid <= 1'b1;
                            r_cnt    <= '0;
                            r_state  <= S_IDLE;
                        end else if (r_fidx >= r_cnt) begin
                            r_cnt   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_sym    <= 16'(r_buf[r_fidx[PW-1:0]]);
                            r_raw    <= 1'b1;
                            r_last   <= (r_fidx + 1'b1 == r_cnt) ||
                                        (r_emitted == 3'(r2k_pkg::RESULT_LIMIT - 1));
                            r_ovalid <= w_cap;
                            r_emitted <= r_emitted + 3'(w_cap);
                            r_fidx   <= r_fidx + 1'b1;
                        end
                    end
                end
                // one rule per cycle
                S_SCAN: begin
                    if (w_head && CW'(w_rule.len) == r_cnt && !r_exact) begin
                        r_exact <= 1'b1;
                        r_hit   <= w_rule;
                    end
                    if (w_head && CW'(w_rule.len) >= r_cnt) r_pref <= 1'b1;
                    if (r_ridx == 8'(NRULE - 1)) r_state <= S_DECIDE;
                    else r_ridx <= r_ridx + 1'b1;
                end
                S_DECIDE: begin
                    if (!r_ovalid || i_ready) begin
                        if (r_fin) begin
                            // release the held result; last if the rest only waits or the result limit is reached
                            r_last    <= (r_pref && !r_exact) ||
                                         (r_emitted == 3'(r2k_pkg::RESULT_LIMIT - 1));
                            r_ovalid  <= w_cap;
                            r_emitted <= r_emitted + 3'(w_cap);
                            r_fin     <= 1'b0;
                            if (r_pref && !r_exact) r_state <= S_IDLE;
                        end else if (r_k1pend) begin
                            r_sym     <= r2k_pkg::to_script(r_hit.k1, i_kata);
                            r_raw     <= 1'b0;
                            r_last    <= 1'b1;
                            r_ovalid  <= w_cap;
                            r_emitted <= r_emitted + 3'(w_cap);
                            r_k1pend  <= 1'b0;
                            r_state   <= S_IDLE;
                        end else if (r_cnt == '0) begin
                            // empty buffer: nothing to resolve
                            r_state <= S_IDLE;
                        end else if (r_exact) begin
                            r_sym     <= r2k_pkg::to_script(r_hit.k0, i_kata);
                            r_raw     <= 1'b0;
                            r_last    <= (r_hit.k1 == 16'h0) ||
                                         (r_emitted == 3'(r2k_pkg::RESULT_LIMIT - 1));
                            r_ovalid  <= w_cap;
                            r_emitted <= r_emitted + 3'(w_cap);
                            r_cnt     <= '0;
                            if (r_hit.k1 != 16'h0) r_k1pend <= 1'b1;
                            else r_state <= S_IDLE;
                        end else if (r_pref) begin
                            r_state <= S_IDLE;
                        end else begin
                            if (r_cnt >= CW'(2) && r_buf[0] == r_buf[1] &&
                                r2k_pkg::is_cons(r_buf[0])) begin
                                r_sym <= r2k_pkg::to_script(r2k_pkg::KANA_SMALL_TSU, i_kata);
                                r_raw <= 1'b0;
                            end else if (r_buf[0] == r2k_pkg::CH_N && r_cnt >= CW'(2)) begin
                                r_sym <= r2k_pkg::to_script(r2k_pkg::KANA_N, i_kata);
                                r_raw <= 1'b0;
                            end else begin
                                r_sym <= 16'(r_buf[0]);
                                r_raw <= 1'b1;
                            end
                            for (int i = 0; i < MAX_PENDING - 1; i++) r_buf[i] <= r_buf[i+1];
                            r_cnt   <= r_cnt - 1'b1;
                            r_ridx  <= '0;
                            r_exact <= 1'b0;
                            r_pref  <= 1'b0;
                            if (r_cnt == CW'(1)) begin
                                r_last    <= 1'b1;
                                r_ovalid  <= w_cap;
                                r_emitted <= r_emitted + 3'(w_cap);
                                r_state   <= S_IDLE;
                            end else begin
                                // hold until the rescan shows whether more follow
                                r_fin   <= 1'b1;
                                r_state <= S_EMIT;
                            end
                        end
                    end
                end
                // result placed; rescan the shifted buffer
                S_EMIT: begin
                    r_state <= S_SCAN;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
